// ===== src/bale_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounded array list engine package
// Operation codes, status codes and field widths shared by the engine.
// ---------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INS_HEAD = 3'd0;
    localparam op_t OP_INS_TAIL = 3'd1;
    localparam op_t OP_REM_HEAD = 3'd2;
    localparam op_t OP_REM_TAIL = 3'd3;
    localparam op_t OP_REM_IDX  = 3'd4;
    localparam op_t OP_RD_IDX   = 3'd5;
    localparam op_t OP_RD_HEAD  = 3'd6;
    localparam op_t OP_RD_TAIL  = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== src/bounded_array_list_engine_top.sv =====
// ---------------------------------------------------------------------------
// Bounded array list engine
// Ordered list of up to CAPACITY words held in one synchronous memory.
// Tail inserts and removes, empty-list head inserts and rejected requests
// finish from idle; reads wait on the memory; other head inserts and non-tail
// removes shift. One request is in flight at a time; busy covers the shifts.
// Shifts move one entry per cycle through the memory's single write port.
// Reset clears the count and the control state; memory contents stay as is.
// Results come out as a one-cycle done strobe; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine_top #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire bale_pkg::op_t               op,
    input  wire logic [bale_pkg::DATA_W-1:0] element,
    input  wire logic [bale_pkg::POS_W-1:0]  position,
    output logic                             busy,
    output logic                             done,
    output logic [bale_pkg::DATA_W-1:0]      read_value,
    output logic [bale_pkg::COUNT_W-1:0]     count,
    output bale_pkg::status_t                status
);

    import bale_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int MW = (ELEM_WIDTH > DATA_W) ? ELEM_WIDTH : DATA_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_RDW  = 3'd4;

    logic [ELEM_WIDTH-1:0] entries_mem [CAPACITY];

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  done_reg, done_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [ELEM_WIDTH-1:0] elem_reg, elem_next;
    logic [DATA_W-1:0]     read_value_reg, read_value_next;
    status_t               status_reg, status_next;

    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    logic [MW-1:0]         elem_wide;
    logic [MW-1:0]         rd_wide;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         idx_x;
    logic                  full;
    logic                  empty;

    assign elem_wide = MW'(element);
    assign rd_wide   = MW'(rd_data_reg);
    assign pos_x     = XW'(position);
    assign cnt_x     = XW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign idx_x     = (op == OP_REM_IDX) ? pos_x : '0;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = cnt_x[COUNT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        ptr_next        = ptr_reg;
        elem_next       = elem_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    read_value_next = '0;
                    status_next     = ST_OK;
                    elem_next       = elem_wide[ELEM_WIDTH-1:0];
                    case (op)
                        OP_INS_HEAD:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (empty)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = elem_wide[ELEM_WIDTH-1:0];
                                count_next = count_reg + CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                // Walk from the tail down, moving each entry up by one.
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                ptr_next   = AW'(count_reg - CW'(1));
                                state_next = S_SHUP;
                            end
                        end
                        OP_INS_TAIL:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = elem_wide[ELEM_WIDTH-1:0];
                                count_next = count_reg + CW'(1);
                            end
                            done_next = 1'b1;
                        end
                        OP_REM_HEAD, OP_REM_IDX:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (idx_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (idx_x + XW'(1) == cnt_x)
                            begin
                                count_next = count_reg - CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(idx_x + XW'(1));
                                ptr_next   = AW'(idx_x + XW'(1));
                                state_next = S_SHDN;
                            end
                        end
                        OP_REM_TAIL:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            done_next = 1'b1;
                        end
                        OP_RD_IDX:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(pos_x);
                                state_next = S_RDW;
                            end
                        end
                        OP_RD_HEAD:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_RDW;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                state_next = S_RDW;
                            end
                        end
                    endcase
                end
            end
            S_SHUP:
            begin
                // Data read last cycle from ptr moves to ptr+1.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + AW'(1);
                mem_wdata = rd_data_reg;
                if (ptr_reg == '0)
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_HEAD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = elem_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SHDN:
            begin
                // Data read last cycle from ptr moves to ptr-1.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - AW'(1);
                mem_wdata = rd_data_reg;
                if (XW'(ptr_reg) + XW'(1) == cnt_x)
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            S_RDW:
            begin
                read_value_next = rd_wide[DATA_W-1:0];
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        elem_reg       <= elem_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= entries_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
